// ===== design/bpu_pkg.sv =====
// Shared types and constants for the BMP pixel unpacker.
// No dependencies; imported by bpu_position, bpu_palette and the top level.
package bpu_pkg;

  // Counter widths; all counts are bounded by the 13-bit geometry registers
  localparam int CNT_W = 13;
  localparam int RBC_W = 15;   // bytes per row, up to 3 * 8191 rounded to 4

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_PIXEL_DEPTH_MODE = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT     = 2'd2;

  // Input transaction kinds
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  // Row strides are padded to a multiple of four bytes
  localparam logic [RBC_W-1:0] STRIDE_ALIGN_MASK = ~RBC_W'(3);

  typedef enum logic [1:0] {
    MODE_1BPP  = 2'd0,
    MODE_4BPP  = 2'd1,
    MODE_8BPP  = 2'd2,
    MODE_24BPP = 2'd3
  } depth_mode_t;

  // One data byte worth of pixels, handed from the position tracker to the emitter
  typedef struct packed {
    logic [7:0]       data;
    depth_mode_t      mode;
    logic [2:0]       cnt_m1;    // pixels in this byte minus one
    logic [CNT_W-1:0] col;       // column of the first pixel
    logic [11:0]      row;       // top-down row
    logic             last_row;  // byte lies in the last file row
    logic [CNT_W-1:0] last_col;  // effective width minus one
    logic [23:0]      rgb;       // assembled pixel for 24-bit mode
  } job_t;

endpackage

// ===== design/bpu_position.sv =====
// Decode position tracker: geometry registers, row/column/stride counters,
// 24-bit byte assembly. Depends on bpu_pkg.
module bpu_position import bpu_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             byte_take,
  input  logic [7:0]       data_byte,
  output job_t             job,
  output logic             job_emit
);

  localparam int LIM_W = 15;

  depth_mode_t      mode_r, mode_nxt;
  logic [CNT_W-1:0] width_r, width_nxt;
  logic [CNT_W-1:0] height_r, height_nxt;
  logic [RBC_W-1:0] rbc_r, rbc_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] frow_r, frow_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [15:0]      held_r, held_nxt;

  logic [CNT_W-1:0] cfg_width_eff, cfg_height_eff;
  logic [RBC_W-1:0] width3, row_bytes, stride, rbc_inc;
  logic [CNT_W-1:0] rem, frow_inc;
  logic [3:0]       n;
  logic             rgb_zone;

  // Clamp geometry: zero means one, large values saturate
  always_comb begin
    if (cfg_data == '0) begin
      cfg_width_eff = CNT_W'(1);
    end else if (LIM_W'(cfg_data) > LIM_W'(MAX_WIDTH)) begin
      cfg_width_eff = CNT_W'(MAX_WIDTH);
    end else begin
      cfg_width_eff = cfg_data;
    end
    if (cfg_data == '0) begin
      cfg_height_eff = CNT_W'(1);
    end else if (LIM_W'(cfg_data) > LIM_W'(MAX_HEIGHT)) begin
      cfg_height_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      cfg_height_eff = cfg_data;
    end
  end

  // Row stride in bytes
  assign width3 = {1'b0, width_r, 1'b0} + RBC_W'(width_r);
  always_comb begin
    case (mode_r)
      MODE_1BPP: row_bytes = (RBC_W'(width_r) + RBC_W'(7)) >> 3;
      MODE_4BPP: row_bytes = (RBC_W'(width_r) + RBC_W'(1)) >> 1;
      MODE_8BPP: row_bytes = RBC_W'(width_r);
      default:   row_bytes = width3;
    endcase
  end
  assign stride = (row_bytes + RBC_W'(3)) & STRIDE_ALIGN_MASK;

  // Pixels produced by the current byte
  assign rem      = width_r - col_r;
  assign rgb_zone = rbc_r < width3;
  always_comb begin
    case (mode_r)
      MODE_1BPP: n = (rem >= CNT_W'(8)) ? 4'd8 : rem[3:0];
      MODE_4BPP: n = (rem >= CNT_W'(2)) ? 4'd2 : rem[3:0];
      MODE_8BPP: n = (rem != '0) ? 4'd1 : 4'd0;
      default:   n = (rgb_zone && phase_r == 2'd2) ? 4'd1 : 4'd0;
    endcase
  end

  assign job_emit     = n != 4'd0;
  assign job.data     = data_byte;
  assign job.mode     = mode_r;
  assign job.cnt_m1   = 3'(n - 4'd1);
  assign job.col      = col_r;
  assign job.row      = 12'(height_r - CNT_W'(1) - frow_r);
  assign job.last_row = frow_r == height_r - CNT_W'(1);
  assign job.last_col = width_r - CNT_W'(1);
  assign job.rgb      = {data_byte, held_r};

  assign rbc_inc  = rbc_r + RBC_W'(1);
  assign frow_inc = frow_r + CNT_W'(1);

  // Next position
  always_comb begin
    mode_nxt   = mode_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    rbc_nxt    = rbc_r;
    col_nxt    = col_r;
    frow_nxt   = frow_r;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_DEPTH_MODE: mode_nxt   = depth_mode_t'(cfg_data[1:0]);
        CFG_IMAGE_WIDTH:      width_nxt  = cfg_width_eff;
        CFG_IMAGE_HEIGHT:     height_nxt = cfg_height_eff;
        default:              ;
      endcase
      if (cfg_index == CFG_PIXEL_DEPTH_MODE || cfg_index == CFG_IMAGE_WIDTH ||
          cfg_index == CFG_IMAGE_HEIGHT) begin
        rbc_nxt   = '0;
        col_nxt   = '0;
        frow_nxt  = '0;
        phase_nxt = '0;
        held_nxt  = '0;
      end
    end else if (byte_take) begin
      // 24-bit assembly: blue, green held, red completes the pixel
      if (mode_r == MODE_24BPP && rgb_zone) begin
        case (phase_r)
          2'd0: begin
            held_nxt  = {8'h00, data_byte};
            phase_nxt = 2'd1;
          end
          2'd1: begin
            held_nxt  = {data_byte, held_r[7:0]};
            phase_nxt = 2'd2;
          end
          default: begin
            held_nxt  = '0;
            phase_nxt = 2'd0;
          end
        endcase
      end
      if (rbc_inc >= stride) begin
        rbc_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = '0;
        held_nxt  = '0;
        frow_nxt  = (frow_inc >= height_r) ? '0 : frow_inc;
      end else begin
        rbc_nxt = rbc_inc;
        col_nxt = col_r + CNT_W'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_8BPP;
      width_r  <= CNT_W'(1);
      height_r <= CNT_W'(1);
      rbc_r    <= '0;
      col_r    <= '0;
      frow_r   <= '0;
      phase_r  <= '0;
      held_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      rbc_r    <= rbc_nxt;
      col_r    <= col_nxt;
      frow_r   <= frow_nxt;
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

// ===== design/bpu_palette.sv =====
// Palette RAM with one write and one registered read port, read-first.
// Per-entry valid bits make unwritten entries read as zero. Depends on bpu_pkg.
module bpu_palette import bpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [23:0] wr_color,
  input  logic        rd_en,
  input  logic [7:0]  rd_index,
  output logic [23:0] rd_color
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0]              mem [0:PALETTE_DEPTH-1];
  logic [PALETTE_DEPTH-1:0] valid_r;
  logic [23:0]              mem_q_r;
  logic                     hit_r;
  logic                     wr_ok, rd_ok;

  // Indexes past the palette are dropped on write and read as zero
  assign wr_ok = wr_en && (9'(wr_index) < 9'(PALETTE_DEPTH));
  assign rd_ok = 9'(rd_index) < 9'(PALETTE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_index[AW-1:0]] <= wr_color;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_index[AW-1:0]];
    end
  end

  // Valid bits stand in for the reset clear of the array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_r[wr_index[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_ok && valid_r[rd_index[AW-1:0]];
      end
    end
  end

  assign rd_color = hit_r ? mem_q_r : 24'h000000;

endmodule

// ===== design/bmp_pixel_unpacker_unit.sv =====
// BMP pixel unpacker top level: input handshake, per-pixel emitter,
// palette lookup pipeline and output register. Depends on bpu_pkg,
// bpu_position and bpu_palette.
//
// Decodes uncompressed BMP pixel data. Palette writes (action 0) and data
// bytes (action 1) share the input channel. While the output does not stall,
// one byte is taken every cycle at 8 and 24 bits per pixel; at 4 and 1 bit a
// byte is held until each of its pixels has issued, one per cycle, paced by
// the single read port of the palette RAM. Padding bytes and the first two
// bytes of a 24-bit pixel emit nothing. Pixels pass the pending-byte register,
// the lookup stage and the output register. A palette write waits until
// every pixel of earlier bytes has read the palette. Reset needs no clearing
// pass: the palette carries one valid bit per entry. A configuration write
// to index 0, 1 or 2 restarts the decode position at the bottom-left pixel.
module bmp_pixel_unpacker_unit import bpu_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [7:0]       in_palette_index,
  input  logic [23:0]      in_palette_color,
  input  logic [7:0]       in_data_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [23:0]      out_pixel_rgb,
  output logic [11:0]      out_pixel_column,
  output logic [11:0]      out_pixel_row,
  output logic             out_image_done,
  output logic             out_run_last
);

  job_t             new_job;
  logic             new_job_emit;
  logic             in_take, byte_take, pal_wr;

  job_t             job_r, job_nxt;
  logic             job_v_r, job_v_nxt;
  logic [2:0]       k_r, k_nxt;
  logic             issue, issue_last;
  logic [CNT_W-1:0] pix_col;
  logic [7:0]       rd_index;
  logic [23:0]      pal_color;

  logic             s1_v_r, s1_v_nxt;
  logic [11:0]      s1_col_r, s1_row_r;
  logic             s1_done_r, s1_last_r, s1_is24_r;
  logic [23:0]      s1_rgb_r;
  logic             s1_ready, s2_ready;

  logic             out_v_r, out_v_nxt;
  logic [23:0]      out_rgb_r;
  logic [11:0]      out_col_r, out_row_r;
  logic             out_done_r, out_last_r;

  // Input handshake: a new transaction enters as the current byte issues its last pixel
  assign s2_ready   = !out_v_r || !out_stall;
  assign s1_ready   = !s1_v_r || s2_ready;
  assign issue      = job_v_r && s1_ready;
  assign issue_last = issue && (k_r == job_r.cnt_m1);
  assign in_stall   = job_v_r && !issue_last;
  assign in_take    = in_valid && !in_stall;
  assign byte_take  = in_take && (in_action == ACT_DATA);
  assign pal_wr     = in_take && (in_action == ACT_PALETTE);

  bpu_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .job       (new_job),
    .job_emit  (new_job_emit)
  );

  // Pending byte and its pixel counter
  always_comb begin
    job_nxt   = job_r;
    job_v_nxt = job_v_r;
    k_nxt     = k_r;
    if (byte_take && new_job_emit) begin
      job_nxt   = new_job;
      job_v_nxt = 1'b1;
      k_nxt     = '0;
    end else if (issue_last) begin
      job_v_nxt = 1'b0;
    end else if (issue) begin
      k_nxt = k_r + 3'd1;
    end
  end

  // Palette index of pixel k
  assign pix_col = job_r.col + CNT_W'(k_r);
  always_comb begin
    case (job_r.mode)
      MODE_1BPP: rd_index = {7'b0, job_r.data[3'd7 - k_r]};
      MODE_4BPP: rd_index = (k_r == 3'd0) ? {4'h0, job_r.data[7:4]}
                                          : {4'h0, job_r.data[3:0]};
      default:   rd_index = job_r.data;
    endcase
  end

  bpu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (pal_wr),
    .wr_index (in_palette_index),
    .wr_color (in_palette_color),
    .rd_en    (issue),
    .rd_index (rd_index),
    .rd_color (pal_color)
  );

  // Lookup stage valid and output register valid
  always_comb begin
    if (issue) begin
      s1_v_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    if (s1_v_r && s2_ready) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      k_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      k_r     <= k_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (issue) begin
      s1_col_r  <= pix_col[11:0];
      s1_row_r  <= job_r.row;
      s1_done_r <= job_r.last_row && (pix_col == job_r.last_col);
      s1_last_r <= k_r == job_r.cnt_m1;
      s1_is24_r <= job_r.mode == MODE_24BPP;
      s1_rgb_r  <= job_r.rgb;
    end
    if (s1_v_r && s2_ready) begin
      out_rgb_r  <= s1_is24_r ? s1_rgb_r : pal_color;
      out_col_r  <= s1_col_r;
      out_row_r  <= s1_row_r;
      out_done_r <= s1_done_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pixel_rgb    = out_rgb_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_row    = out_row_r;
  assign out_image_done   = out_done_r;
  assign out_run_last     = out_last_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for bmp_pixel_unpacker_unit: directed rows, a back-pressure
// phase and random images, each pixel checked against an in-bench decoder or a typed row.
// Depends on bpu_pkg and the bmp_pixel_unpacker_unit RTL.
module tb_top;
  import bpu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int ITEMS = 370;
  localparam int SETTLE = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;
  localparam int N_DIR = 25;
  // register index that the block does not implement
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PAL,
    ROW_DATA
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [12:0] reg_val;
    logic [7:0]  pal_idx;
    logic [23:0] color;
    logic [7:0]  dbyte;
    logic        typed;
    logic [23:0] t_rgb;
    logic [11:0] t_col;
    logic [11:0] t_row;
    logic        t_done;
  } dir_row_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic [11:0] col;
    logic [11:0] row;
    logic        done;
    logic        last;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CNT_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [7:0]       in_palette_index;
  logic [23:0]      in_palette_color;
  logic [7:0]       in_data_byte;
  logic             out_valid;
  logic             out_stall;
  logic [23:0]      out_pixel_rgb;
  logic [11:0]      out_pixel_column;
  logic [11:0]      out_pixel_row;
  logic             out_image_done;
  logic             out_run_last;

  // decoder state kept by the bench
  logic [23:0] palette [256];
  depth_mode_t cur_mode;
  logic [12:0] cur_width;
  logic [12:0] cur_height;
  int          row_byte;
  int          col_pos;
  int          file_row;
  int          rgb_phase;
  logic [15:0] held;

  pixel_t pending_pixels [$];
  pixel_t head_px;
  int     mismatches = 0;
  int     txns_sent = 0;
  int     stuck_cycles = 0;
  bit     gaps_on;
  bit     stall_on;
  bit     hold_req;

  // directed rows; typed expectations only where obvious
  dir_row_t dir_rows [N_DIR] = '{
    // palette is clear after reset: 8 bpp, 1x1 image
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'hA5, 1'b1, 24'h000000, 12'd0, 12'd0, 1'b1},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'hFF, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h5A, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_PAL, 2'd0, 13'd0, 8'h00, 24'hFFFFFF, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_PAL, 2'd0, 13'd0, 8'hFF, 24'h123456, 8'hFF, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_PAL, 2'd0, 13'd0, 8'h01, 24'hABCDEF, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_PAL, 2'd0, 13'd0, 8'h0F, 24'hF0F0F0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'hFF, 1'b1, 24'h123456, 12'd0, 12'd0, 1'b1},
    // unknown register leaves the position alone
    '{ROW_CFG, CFG_UNUSED, 13'h1FFF, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    // 1 bpp, zero width, oversized height
    '{ROW_CFG, CFG_PIXEL_DEPTH_MODE, 13'(MODE_1BPP), 8'h00, 24'h0, 8'h00, 1'b0, 24'h0,
      12'd0, 12'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_WIDTH, 13'd0, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'h1FFF, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0,
      1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h80, 1'b1, 24'hABCDEF, 12'd0, 12'd4095,
      1'b0},
    // 4 bpp at oversized width
    '{ROW_CFG, CFG_PIXEL_DEPTH_MODE, 13'(MODE_4BPP), 8'h00, 24'h0, 8'h00, 1'b0, 24'h0,
      12'd0, 12'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_WIDTH, 13'h1FFF, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0,
      1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'hF1, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    // 24 bpp, 1x1, B G R then one padding byte
    '{ROW_CFG, CFG_PIXEL_DEPTH_MODE, 13'(MODE_24BPP), 8'h00, 24'h0, 8'h00, 1'b0, 24'h0,
      12'd0, 12'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_WIDTH, 13'd1, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd1, 8'h00, 24'h0, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h11, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h22, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h33, 1'b1, 24'h332211, 12'd0, 12'd0, 1'b1},
    '{ROW_DATA, 2'd0, 13'd0, 8'h00, 24'h000000, 8'h00, 1'b0, 24'h0, 12'd0, 12'd0, 1'b0}
  };

  bmp_pixel_unpacker_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_palette_index (in_palette_index),
    .in_palette_color (in_palette_color),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_rgb    (out_pixel_rgb),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_image_done   (out_image_done),
    .out_run_last     (out_run_last)
  );

  always #1 clk = ~clk;

  // ---------------- decoder model ----------------

  function automatic int eff_dim(input logic [12:0] v, input int cap);
    if (v == 13'd0) return 1;
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  function automatic int row_stride();
    int bpp;
    int bytes;
    case (cur_mode)
      MODE_1BPP: bpp = 1;
      MODE_4BPP: bpp = 4;
      MODE_8BPP: bpp = 8;
      default:   bpp = 24;
    endcase
    bytes = (eff_dim(cur_width, MAX_W) * bpp + 7) >> 3;
    return (bytes + 3) & ~3;
  endfunction

  function automatic void clear_position();
    row_byte = 0;
    col_pos = 0;
    file_row = 0;
    rgb_phase = 0;
    held = '0;
  endfunction

  function automatic void reset_model();
    foreach (palette[i]) palette[i] = '0;
    cur_mode = MODE_8BPP;
    cur_width = 13'd1;
    cur_height = 13'd1;
    clear_position();
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      CFG_PIXEL_DEPTH_MODE: cur_mode = depth_mode_t'(val[1:0]);
      CFG_IMAGE_WIDTH:      cur_width = val;
      CFG_IMAGE_HEIGHT:     cur_height = val;
      default:              return;
    endcase
    clear_position();
  endfunction

  // Decode one data byte, queue the pixels it yields, advance the position
  function automatic int decode_byte(input logic [7:0] b);
    int w;
    int h;
    int stride;
    int row_out;
    int bi;
    int n;
    logic [23:0] colors [8];
    pixel_t px;
    w = eff_dim(cur_width, MAX_W);
    h = eff_dim(cur_height, MAX_H);
    stride = row_stride();
    row_out = h - 1 - file_row;
    n = 0;
    case (cur_mode)
      MODE_1BPP: begin
        for (bi = 7; bi >= 0; bi--)
          if (col_pos + n < w) begin
            colors[n] = palette[{7'd0, b[bi]}];
            n++;
          end
      end
      MODE_4BPP: begin
        if (col_pos < w) begin
          colors[n] = palette[{4'd0, b[7:4]}];
          n++;
        end
        if (col_pos + n < w) begin
          colors[n] = palette[{4'd0, b[3:0]}];
          n++;
        end
      end
      MODE_8BPP: begin
        if (col_pos < w) begin
          colors[0] = palette[b];
          n = 1;
        end
      end
      default: begin
        // blue, green held until red arrives
        if (row_byte < 3 * w) begin
          if (rgb_phase == 0) begin
            held = {8'h00, b};
            rgb_phase = 1;
          end else if (rgb_phase == 1) begin
            held[15:8] = b;
            rgb_phase = 2;
          end else begin
            colors[0] = {b, held};
            n = 1;
            rgb_phase = 0;
            held = '0;
          end
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      px.rgb = colors[k];
      px.col = col_pos[11:0];
      px.row = row_out[11:0];
      px.done = (file_row == h - 1) && (col_pos == w - 1);
      px.last = (k == n - 1);
      pending_pixels.push_back(px);
      col_pos++;
    end
    row_byte++;
    if (row_byte >= stride) begin
      row_byte = 0;
      col_pos = 0;
      rgb_phase = 0;
      held = '0;
      file_row++;
      if (file_row >= h) file_row = 0;
    end
    return n;
  endfunction

  // ---------------- drivers ----------------

  // Offer one transaction, wait for it to be taken, then update the model
  task automatic send_txn(input logic act, input logic [7:0] pidx, input logic [23:0] pcol,
                          input logic [7:0] dbyte, output int n);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_palette_index <= pidx;
    in_palette_color <= pcol;
    in_data_byte <= dbyte;
    do @(posedge clk); while (in_stall);
    txns_sent++;
    n = 0;
    if (act == ACT_PALETTE) palette[pidx] = pcol;
    else n = decode_byte(dbyte);
  endtask

  task automatic send_palette_rand();
    int n;
    logic [7:0] idx;
    idx = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    send_txn(ACT_PALETTE, idx, 24'($urandom), 8'($urandom), n);
  endtask

  task automatic send_data_rand();
    int n;
    send_txn(ACT_DATA, 8'($urandom), 24'($urandom), 8'($urandom_range(0, 255)), n);
  endtask

  // Drain the block before touching the registers
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Mostly small sizes, sometimes zero, the maximum or beyond it
  function automatic logic [12:0] pick_dim(input int top);
    case ($urandom_range(0, 15))
      0:       return 13'd0;
      1:       return 13'h1FFF;
      2:       return 13'd4096;
      3:       return 13'($urandom_range(4097, 8190));
      default: return 13'($urandom_range(1, top));
    endcase
  endfunction

  // One random phase: new settings, some palette writes, then image bytes
  task automatic run_phase();
    int nbytes;
    quiesce();
    gaps_on = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) != 0) cfg_write(CFG_PIXEL_DEPTH_MODE, 13'($urandom_range(0, 8191)));
    if ($urandom_range(0, 3) != 0) cfg_write(CFG_IMAGE_WIDTH, pick_dim(12));
    if ($urandom_range(0, 3) != 0) cfg_write(CFG_IMAGE_HEIGHT, pick_dim(3));
    if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED, 13'($urandom_range(0, 8191)));
    repeat ($urandom_range(0, 6)) send_palette_rand();
    nbytes = row_stride() * eff_dim(cur_height, MAX_H);
    if (nbytes > 128) begin
      nbytes = $urandom_range(8, 40);
    end else begin
      if ($urandom_range(0, 1) != 0) nbytes = nbytes * 2;
      // occasionally cut the image short
      if ($urandom_range(0, 5) == 0) nbytes = $urandom_range(1, nbytes);
    end
    // keep the total near the planned transaction count
    if (nbytes > ITEMS - txns_sent) nbytes = ITEMS - txns_sent;
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 11) == 0) send_palette_rand();
      send_data_rand();
    end
  endtask

  // ---------------- result side ----------------

  // Receiver: random stall before each transaction, one long hold on request
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = stall_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic cmp_field(input string name, input int expv, input int gotv);
    if (expv != gotv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, gotv);
      mismatches++;
    end
  endtask

  // Scoreboard: each accepted pixel against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual rgb %0h col %0d row %0d",
                 $time, out_pixel_rgb, out_pixel_column, out_pixel_row);
        mismatches++;
      end else begin
        head_px = pending_pixels.pop_front();
        cmp_field("pixel_rgb", head_px.rgb, out_pixel_rgb);
        cmp_field("pixel_column", head_px.col, out_pixel_column);
        cmp_field("pixel_row", head_px.row, out_pixel_row);
        cmp_field("image_done", head_px.done, out_image_done);
        cmp_field("run_last", head_px.last, out_run_last);
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin : main_seq
    int n;
    pixel_t px;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_DATA;
    in_palette_index = '0;
    in_palette_color = '0;
    in_data_byte = '0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    hold_req = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_DIR; i++) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          quiesce();
          cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        end
        ROW_PAL: begin
          send_txn(ACT_PALETTE, dir_rows[i].pal_idx, dir_rows[i].color, dir_rows[i].dbyte, n);
        end
        default: begin
          send_txn(ACT_DATA, dir_rows[i].pal_idx, dir_rows[i].color, dir_rows[i].dbyte, n);
          if (dir_rows[i].typed) begin
            repeat (n) void'(pending_pixels.pop_back());
            px.rgb = dir_rows[i].t_rgb;
            px.col = dir_rows[i].t_col;
            px.row = dir_rows[i].t_row;
            px.done = dir_rows[i].t_done;
            px.last = 1'b1;
            pending_pixels.push_back(px);
          end
        end
      endcase
    end

    // back-pressure: 1 bpp bytes streamed back to back while the receiver holds off
    quiesce();
    gaps_on = 1'b0;
    stall_on = 1'b1;
    cfg_write(CFG_PIXEL_DEPTH_MODE, 13'(MODE_1BPP));
    cfg_write(CFG_IMAGE_WIDTH, 13'd64);
    cfg_write(CFG_IMAGE_HEIGHT, 13'd2);
    send_txn(ACT_PALETTE, 8'h00, 24'($urandom), 8'h00, n);
    send_txn(ACT_PALETTE, 8'h01, 24'($urandom), 8'h00, n);
    hold_req = 1'b1;
    repeat (16) send_data_rand();

    // random images
    while (txns_sent < ITEMS) run_phase();

    quiesce();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
